>>> rtl/tmcr_pkg.sv
// ----------------------------------------------------------------------------
// tmcr_pkg: shared definitions for the text mode cell renderer
// Operation codes, default geometry, fixed field widths and the color palette.
// ----------------------------------------------------------------------------
package tmcr_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_WRITE_CELL = 2'd0,
    OP_LOAD_FONT  = 2'd1,
    OP_RENDER     = 2'd2
  } op_t;

  // Default text geometry.
  localparam int DEF_TEXT_COLUMNS = 80;
  localparam int DEF_TEXT_ROWS    = 25;
  localparam int DEF_GLYPH_HEIGHT = 16;

  // Fixed field widths.
  localparam int OP_W    = 2;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int FADDR_W = 12;
  localparam int FBYTE_W = 8;
  localparam int SCAN_W  = 9;
  localparam int PIX_W   = 8;

  // Glyph store: 256 codes with a stride of 16 lines each.
  localparam int GLYPH_COUNT = 4096;
  localparam int GLINE_W     = 4;
  localparam int CELL_W      = CHAR_W + ATTR_W;

  // Cycles from an accepted render request to its result strobe.
  localparam int RENDER_LATENCY = 6;

  localparam logic [PIX_W-1:0] SYNC_BITS = 8'hC0;

  localparam logic [PIX_W-1:0] PALETTE [16] = '{
    8'h00, 8'h02, 8'h08, 8'h0A, 8'h20, 8'h22, 8'h28, 8'h2A,
    8'h15, 8'h17, 8'h1D, 8'h1F, 8'h35, 8'h37, 8'h3D, 8'h3F
  };

  // Palette lookup with the sync bits merged in.
  function automatic logic [PIX_W-1:0] palette_color(input logic [3:0] idx);
    return PALETTE[idx] | SYNC_BITS;
  endfunction

endpackage

>>> rtl/text_mode_cell_renderer.sv
// ----------------------------------------------------------------------------
// text_mode_cell_renderer: character generator for a text overlay
// Keeps a cell store of character and attribute pairs and a glyph store of
// font rows, and turns one render request into eight palette pixels.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Handshake
//   --------  -----------------------------  -----------------------------------
//   request   in_op .. in_scan_line          taken when start is high, busy low
//   result    out_column_out, out_pixel_0..7 out_valid strobe, one cycle, no stall
//   config    cfg_data (overlay_visible)     written when cfg_we is high
//
// A new request is taken every cycle while busy is low. Only renders
// with the overlay on and inside the text area give a result.
// The throughput is set by the single access per cycle on each of the two
// block RAMs: the cell store is accessed in stage C and the glyph store in
// stage D, so requests reach each memory in order and never collide.
// Busy is high during reset and for the first cycle after it. There is no
// clearing pass: both stores are undefined until the host writes them.
//
module text_mode_cell_renderer
  import tmcr_pkg::*;
#(
  parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
  parameter int TEXT_ROWS    = DEF_TEXT_ROWS,
  parameter int GLYPH_HEIGHT = DEF_GLYPH_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [COL_W-1:0]   in_col,
  input  logic [ROW_W-1:0]   in_row,
  input  logic [CHAR_W-1:0]  in_character,
  input  logic [ATTR_W-1:0]  in_attribute,
  input  logic [FADDR_W-1:0] in_font_address,
  input  logic [FBYTE_W-1:0] in_font_byte,
  input  logic [SCAN_W-1:0]  in_scan_line,
  // result channel
  output logic               out_valid,
  output logic [COL_W-1:0]   out_column_out,
  output logic [PIX_W-1:0]   out_pixel_0,
  output logic [PIX_W-1:0]   out_pixel_1,
  output logic [PIX_W-1:0]   out_pixel_2,
  output logic [PIX_W-1:0]   out_pixel_3,
  output logic [PIX_W-1:0]   out_pixel_4,
  output logic [PIX_W-1:0]   out_pixel_5,
  output logic [PIX_W-1:0]   out_pixel_6,
  output logic [PIX_W-1:0]   out_pixel_7,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_data
);

  // Geometry of the cell store.
  localparam int CELL_DEPTH = TEXT_COLUMNS * TEXT_ROWS;
  localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int GLYPH_AW   = $clog2(GLYPH_COUNT);

  // The scanline is split into character row and glyph line by a multiply
  // with a truncated reciprocal. The estimate is at most one below the true
  // quotient for any 9-bit scanline, so one compare and subtract fixes it.
  localparam int DIV_SHIFT = 16;
  localparam int RECIP     = (1 << DIV_SHIFT) / GLYPH_HEIGHT;
  localparam int QW        = $clog2((1 << SCAN_W) / GLYPH_HEIGHT + 1);
  localparam int PW        = DIV_SHIFT + QW + 1;
  localparam int RW        = $clog2(2 * GLYPH_HEIGHT);
  localparam int MW        = 16;

  // Busy only covers reset and the cycle after it.
  logic busy_r;
  logic in_fire;
  assign in_fire = start & ~busy_r;
  assign busy    = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Overlay enable register.
  logic overlay_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overlay_r <= 1'b0;
    end else if (cfg_we) begin
      overlay_r <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: capture the request and start the scanline reciprocal multiply.
  // --------------------------------------------------------------------------
  logic               a_valid_r;
  logic [OP_W-1:0]    a_op_r;
  logic [COL_W-1:0]   a_col_r;
  logic [ROW_W-1:0]   a_row_r;
  logic [CHAR_W-1:0]  a_chr_r;
  logic [ATTR_W-1:0]  a_attr_r;
  logic [FADDR_W-1:0] a_faddr_r;
  logic [FBYTE_W-1:0] a_fbyte_r;
  logic [SCAN_W-1:0]  a_line_r;
  logic [PW-1:0]      a_prod_r;
  logic [PW-1:0]      a_prod_nxt;

  assign a_prod_nxt = PW'(in_scan_line) * PW'(RECIP);

  always_ff @(posedge clk) begin
    a_op_r    <= in_op;
    a_col_r   <= in_col;
    a_row_r   <= in_row;
    a_chr_r   <= in_character;
    a_attr_r  <= in_attribute;
    a_faddr_r <= in_font_address;
    a_fbyte_r <= in_font_byte;
    a_line_r  <= in_scan_line;
    a_prod_r  <= a_prod_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage B: quotient estimate and its remainder.
  // --------------------------------------------------------------------------
  logic               b_valid_r;
  logic [OP_W-1:0]    b_op_r;
  logic [COL_W-1:0]   b_col_r;
  logic [ROW_W-1:0]   b_row_r;
  logic [CHAR_W-1:0]  b_chr_r;
  logic [ATTR_W-1:0]  b_attr_r;
  logic [FADDR_W-1:0] b_faddr_r;
  logic [FBYTE_W-1:0] b_fbyte_r;
  logic [QW-1:0]      b_q_r;
  logic [RW-1:0]      b_rem_r;
  logic [QW-1:0]      b_q_nxt;
  logic [SCAN_W-1:0]  b_rem_full;

  assign b_q_nxt    = a_prod_r[DIV_SHIFT +: QW];
  assign b_rem_full = a_line_r - SCAN_W'(SCAN_W'(b_q_nxt) * SCAN_W'(GLYPH_HEIGHT));

  always_ff @(posedge clk) begin
    b_op_r    <= a_op_r;
    b_col_r   <= a_col_r;
    b_row_r   <= a_row_r;
    b_chr_r   <= a_chr_r;
    b_attr_r  <= a_attr_r;
    b_faddr_r <= a_faddr_r;
    b_fbyte_r <= a_fbyte_r;
    b_q_r     <= b_q_nxt;
    b_rem_r   <= b_rem_full[RW-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage B to C: correct the quotient, form the cell address, check ranges.
  // Both candidate addresses are formed so the correction only steers a mux.
  // --------------------------------------------------------------------------
  logic               is_render;
  logic               wrap;
  logic [MW-1:0]      mrow;
  logic [MW-1:0]      base_addr;
  logic [MW-1:0]      cell_addr;
  logic [MW-1:0]      crow;
  logic               col_ok;
  logic [RW-1:0]      gline_full;

  logic               c_cell_we_nxt;
  logic               c_render_nxt;
  logic               c_font_we_nxt;

  assign is_render  = (b_op_r == OP_RENDER);
  assign wrap       = (b_rem_r >= RW'(GLYPH_HEIGHT));
  assign mrow       = is_render ? MW'(b_q_r) : MW'(b_row_r);
  assign base_addr  = mrow * MW'(TEXT_COLUMNS) + MW'(b_col_r);
  assign cell_addr  = (is_render && wrap) ? base_addr + MW'(TEXT_COLUMNS) : base_addr;
  assign crow       = MW'(b_q_r) + MW'(wrap);
  assign col_ok     = MW'(b_col_r) < MW'(TEXT_COLUMNS);
  assign gline_full = wrap ? b_rem_r - RW'(GLYPH_HEIGHT) : b_rem_r;

  assign c_cell_we_nxt = b_valid_r && (b_op_r == OP_WRITE_CELL) && col_ok &&
                         (MW'(b_row_r) < MW'(TEXT_ROWS));
  assign c_render_nxt  = b_valid_r && is_render && overlay_r && col_ok &&
                         (crow < MW'(TEXT_ROWS));
  assign c_font_we_nxt = b_valid_r && (b_op_r == OP_LOAD_FONT);

  // --------------------------------------------------------------------------
  // Stage C: cell store access (write or read).
  // --------------------------------------------------------------------------
  logic               c_cell_we_r;
  logic               c_render_r;
  logic               c_font_we_r;
  logic [CELL_AW-1:0] c_cell_addr_r;
  logic [CELL_W-1:0]  c_cell_wdata_r;
  logic [COL_W-1:0]   c_col_r;
  logic [GLINE_W-1:0] c_gline_r;
  logic [FADDR_W-1:0] c_faddr_r;
  logic [FBYTE_W-1:0] c_fbyte_r;
  logic [CELL_W-1:0]  cell_rdata;

  always_ff @(posedge clk) begin
    c_cell_addr_r  <= cell_addr[CELL_AW-1:0];
    c_cell_wdata_r <= {b_attr_r, b_chr_r};
    c_col_r        <= b_col_r;
    c_gline_r      <= GLINE_W'(gline_full);
    c_faddr_r      <= b_faddr_r;
    c_fbyte_r      <= b_fbyte_r;
  end

  tmcr_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_DEPTH),
    .AW    (CELL_AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (c_cell_we_r),
    .waddr (c_cell_addr_r),
    .wdata (c_cell_wdata_r),
    .raddr (c_cell_addr_r),
    .rdata (cell_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage D: glyph store access. The read address comes straight from the
  // cell code that the cell store returns in this cycle.
  // --------------------------------------------------------------------------
  logic                d_render_r;
  logic                d_font_we_r;
  logic [COL_W-1:0]    d_col_r;
  logic [GLINE_W-1:0]  d_gline_r;
  logic [FADDR_W-1:0]  d_faddr_r;
  logic [FBYTE_W-1:0]  d_fbyte_r;
  logic [GLYPH_AW-1:0] glyph_raddr;
  logic [FBYTE_W-1:0]  glyph_rdata;

  assign glyph_raddr = {cell_rdata[CHAR_W-1:0], d_gline_r};

  always_ff @(posedge clk) begin
    d_col_r   <= c_col_r;
    d_gline_r <= c_gline_r;
    d_faddr_r <= c_faddr_r;
    d_fbyte_r <= c_fbyte_r;
  end

  tmcr_ram #(
    .WIDTH (FBYTE_W),
    .DEPTH (GLYPH_COUNT),
    .AW    (GLYPH_AW)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (d_font_we_r),
    .waddr (d_faddr_r),
    .wdata (d_fbyte_r),
    .raddr (glyph_raddr),
    .rdata (glyph_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage E: expand the glyph row through the palette.
  // --------------------------------------------------------------------------
  logic               e_render_r;
  logic [COL_W-1:0]   e_col_r;
  logic [ATTR_W-1:0]  e_attr_r;
  logic [PIX_W-1:0]   fg_color;
  logic [PIX_W-1:0]   bg_color;
  logic [PIX_W-1:0]   pix_nxt [8];

  always_ff @(posedge clk) begin
    e_col_r  <= d_col_r;
    e_attr_r <= cell_rdata[CELL_W-1:CHAR_W];
  end

  assign fg_color = palette_color(e_attr_r[3:0]);
  assign bg_color = palette_color(e_attr_r[7:4]);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      pix_nxt[b] = glyph_rdata[b] ? fg_color : bg_color;
    end
  end

  // --------------------------------------------------------------------------
  // Output registers.
  // --------------------------------------------------------------------------
  logic               out_valid_r;
  logic [COL_W-1:0]   out_col_r;
  logic [PIX_W-1:0]   out_pix_r [8];

  always_ff @(posedge clk) begin
    out_col_r <= e_col_r;
    for (int b = 0; b < 8; b++) begin
      out_pix_r[b] <= pix_nxt[b];
    end
  end

  // Valid and write enable bits along the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_cell_we_r <= 1'b0;
      c_render_r  <= 1'b0;
      c_font_we_r <= 1'b0;
      d_render_r  <= 1'b0;
      d_font_we_r <= 1'b0;
      e_render_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= in_fire;
      b_valid_r   <= a_valid_r;
      c_cell_we_r <= c_cell_we_nxt;
      c_render_r  <= c_render_nxt;
      c_font_we_r <= c_font_we_nxt;
      d_render_r  <= c_render_r;
      d_font_we_r <= c_font_we_r;
      e_render_r  <= d_render_r;
      out_valid_r <= e_render_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_column_out = out_col_r;
  assign out_pixel_0    = out_pix_r[0];
  assign out_pixel_1    = out_pix_r[1];
  assign out_pixel_2    = out_pix_r[2];
  assign out_pixel_3    = out_pix_r[3];
  assign out_pixel_4    = out_pix_r[4];
  assign out_pixel_5    = out_pix_r[5];
  assign out_pixel_6    = out_pix_r[6];
  assign out_pixel_7    = out_pix_r[7];

endmodule

>>> rtl/tmcr_ram.sv
// ----------------------------------------------------------------------------
// tmcr_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tmcr_checker.sv
// ----------------------------------------------------------------------------
// tmcr_checker: port level checks for the text mode cell renderer
// Watches the request and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module tmcr_checker
  import tmcr_pkg::*;
#(
  parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS
) (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [OP_W-1:0]  in_op,
  input logic [COL_W-1:0] in_col,
  input logic             out_valid,
  input logic [COL_W-1:0] out_column_out,
  input logic [PIX_W-1:0] out_pixel_0,
  input logic [PIX_W-1:0] out_pixel_1,
  input logic [PIX_W-1:0] out_pixel_2,
  input logic [PIX_W-1:0] out_pixel_3,
  input logic [PIX_W-1:0] out_pixel_4,
  input logic [PIX_W-1:0] out_pixel_5,
  input logic [PIX_W-1:0] out_pixel_6,
  input logic [PIX_W-1:0] out_pixel_7
);

  // Every result comes from a render request taken a fixed time earlier.
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, RENDER_LATENCY) &&
                  $past(in_op, RENDER_LATENCY) == OP_RENDER)
    else $error("result without a matching render request");

  // The reported column is the column of that request.
  a_result_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_column_out == $past(in_col, RENDER_LATENCY))
    else $error("result column differs from its request");

  // Only columns inside the text area are ever rendered.
  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_column_out) < TEXT_COLUMNS)
    else $error("result for a column beyond the text area");

  // Every pixel carries the sync bits.
  a_sync_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pixel_0 & out_pixel_1 & out_pixel_2 & out_pixel_3 &
                    out_pixel_4 & out_pixel_5 & out_pixel_6 & out_pixel_7 &
                    SYNC_BITS) == SYNC_BITS))
    else $error("pixel without sync bits");

endmodule

bind text_mode_cell_renderer tmcr_checker #(
  .TEXT_COLUMNS (TEXT_COLUMNS)
) u_tmcr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_op          (in_op),
  .in_col         (in_col),
  .out_valid      (out_valid),
  .out_column_out (out_column_out),
  .out_pixel_0    (out_pixel_0),
  .out_pixel_1    (out_pixel_1),
  .out_pixel_2    (out_pixel_2),
  .out_pixel_3    (out_pixel_3),
  .out_pixel_4    (out_pixel_4),
  .out_pixel_5    (out_pixel_5),
  .out_pixel_6    (out_pixel_6),
  .out_pixel_7    (out_pixel_7)
);
